### design/swd_pkg.sv
// swd_pkg: shared types and constants for the swipe gesture detector
// used by swd_regs, swd_core and the top level

package swd_pkg;

  localparam int DeltaW    = 16;
  localparam int TimeW     = 63;
  localparam int SumW      = 32;
  localparam int DeadlineW = 64;
  localparam int ThreshW   = 32;
  localparam int CoolW     = 16;
  localparam int AddrW     = 3;
  localparam int DataW     = 32;

  // register map index, taken from paddr[2]
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_COOLDOWN  = 1'b1;

  localparam logic [ThreshW-1:0] THRESHOLD_RESET = 32'd100;
  localparam logic [CoolW-1:0]   COOLDOWN_RESET  = 16'd300;

  typedef enum logic [2:0] {
    DIR_NONE  = 3'd0,
    DIR_LEFT  = 3'd1,
    DIR_RIGHT = 3'd2,
    DIR_UP    = 3'd3,
    DIR_DOWN  = 3'd4
  } dir_t;

  typedef struct packed {
    logic                     axis_select;
    logic signed [DeltaW-1:0] delta;
    logic                     sync_flag;
    logic [TimeW-1:0]         time_ms;
  } item_t;

  typedef struct packed {
    logic [ThreshW-1:0] swipe_threshold;
    logic [CoolW-1:0]   cooldown_time;
  } cfg_t;

endpackage

### design/swd_regs.sv
// swd_regs: apb configuration registers (threshold and cooldown time)
// depends on swd_pkg

module swd_regs
  import swd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // word aligned map, low address bits ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.swipe_threshold <= THRESHOLD_RESET;
      cfg.cooldown_time   <= COOLDOWN_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_THRESHOLD: cfg.swipe_threshold <= pwdata[ThreshW-1:0];
        REG_COOLDOWN:  cfg.cooldown_time   <= pwdata[CoolW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_THRESHOLD: prdata = cfg.swipe_threshold;
      REG_COOLDOWN:  prdata = {{(DataW-CoolW){1'b0}}, cfg.cooldown_time};
      default:       prdata = '0;
    endcase
  end

  // paddr[1:0] and psel/penable beyond the write are only part of the bus
  logic unused_addr;
  assign unused_addr = ^paddr[1:0];

endmodule

### design/swd_core.sv
// swd_core: accumulator state, threshold compare and cooldown tracking
// one item evaluated per advance; depends on swd_pkg

module swd_core
  import swd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  advance,
  input  item_t item,
  input  cfg_t  cfg,
  output dir_t  direction
);

  logic signed [SumW-1:0]  sum_x, sum_x_next;
  logic signed [SumW-1:0]  sum_y, sum_y_next;
  logic [DeadlineW-1:0]    cooldown_deadline, cooldown_deadline_next;
  logic                    cooling, cooling_next;

  logic signed [SumW-1:0]  sel_sum;
  logic signed [SumW:0]    wide_sum;
  logic signed [SumW-1:0]  sat_sum;
  logic signed [SumW-1:0]  acc_x, acc_y;
  logic [SumW-1:0]         mag_x, mag_y;
  logic [SumW:0]           mag_total;
  logic                    trigger;
  logic                    deadline_hit;

  always_comb begin
    sel_sum  = item.axis_select ? sum_y : sum_x;
    wide_sum = {sel_sum[SumW-1], sel_sum}
             + {{(SumW+1-DeltaW){item.delta[DeltaW-1]}}, item.delta};
    // saturate when the two top bits disagree
    if (wide_sum[SumW] != wide_sum[SumW-1])
      sat_sum = wide_sum[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    else
      sat_sum = wide_sum[SumW-1:0];

    acc_x = item.axis_select ? sum_x : sat_sum;
    acc_y = item.axis_select ? sat_sum : sum_y;

    // most negative value maps to 2^31, still fits unsigned 32 bits
    mag_x = acc_x[SumW-1] ? SumW'(-acc_x) : acc_x;
    mag_y = acc_y[SumW-1] ? SumW'(-acc_y) : acc_y;
    mag_total = {1'b0, mag_x} + {1'b0, mag_y};
    trigger = item.sync_flag && (mag_total >= {1'b0, cfg.swipe_threshold});

    deadline_hit = item.sync_flag && ({1'b0, item.time_ms} >= cooldown_deadline);

    sum_x_next             = acc_x;
    sum_y_next             = acc_y;
    cooling_next           = cooling;
    cooldown_deadline_next = cooldown_deadline;
    direction              = DIR_NONE;

    if (cooling) begin
      sum_x_next = '0;
      sum_y_next = '0;
      if (deadline_hit) cooling_next = 1'b0;
    end else if (trigger) begin
      sum_x_next             = '0;
      sum_y_next             = '0;
      cooling_next           = 1'b1;
      cooldown_deadline_next = {1'b0, item.time_ms}
                             + {{(DeadlineW-CoolW){1'b0}}, cfg.cooldown_time};
      // ties go to the horizontal axis
      if (mag_x >= mag_y) direction = acc_x[SumW-1] ? DIR_LEFT : DIR_RIGHT;
      else                direction = acc_y[SumW-1] ? DIR_UP : DIR_DOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x             <= '0;
      sum_y             <= '0;
      cooldown_deadline <= '0;
      cooling           <= 1'b0;
    end else if (advance) begin
      sum_x             <= sum_x_next;
      sum_y             <= sum_y_next;
      cooldown_deadline <= cooldown_deadline_next;
      cooling           <= cooling_next;
    end
  end

endmodule

### design/swipe_gesture_detector.sv
// swipe_gesture_detector: top level, input register, result register and apb port
// depends on swd_pkg, swd_regs, swd_core
//
//  channel  | dir | fields (low bit up)                           | transfer
//  ---------+-----+-----------------------------------------------+-------------------------
//  s_*      | in  | tdata: delta, time_ms, pad; tuser: axis;      | s_tvalid & s_tready
//           |     | tlast: sync_flag                              |
//  m_*      | out | tdata: direction, pad                         | m_tvalid & m_tready
//  apb      | in  | swipe_threshold @0x0, cooldown_time @0x4      | psel & penable & pwrite
//
// one item per cycle sustained while m_tready stays high; a result moves through the registers
// in order (input register, then evaluation into the result register)
// the accumulator state updates as an item moves into the result register, so the next
// item in the input register always sees the settled state
// synchronous reset clears the accumulator state, the configuration registers and both valid flags
// a stalled m side fills the result register and then the input register, then s_tready drops

module swipe_gesture_detector
  import swd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // apb configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  // input stream
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [79:0]      s_tdata,   // [15:0] delta, [78:16] time_ms, [79] zero
  input  logic             s_tuser,   // [0] axis_select
  input  logic             s_tlast,   // sync_flag
  // result stream
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata    // [2:0] direction, [7:3] zero
);

  cfg_t  cfg;
  item_t in_item;
  logic  in_vld;
  logic  out_vld;
  dir_t  out_dir;
  dir_t  core_dir;
  logic  advance;
  logic  in_take;

  swd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance  = in_vld && (!out_vld || m_tready);
  assign s_tready = !in_vld || advance;
  assign in_take  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_take) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item.axis_select <= s_tuser;
      in_item.delta       <= s_tdata[DeltaW-1:0];
      in_item.sync_flag   <= s_tlast;
      in_item.time_ms     <= s_tdata[DeltaW +: TimeW];
    end
  end

  swd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .item      (in_item),
    .cfg       (cfg),
    .direction (core_dir)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (m_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_dir <= core_dir;
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = {5'b0, out_dir};

  // pad bit of the input word carries nothing
  logic unused_pad;
  assign unused_pad = s_tdata[79];

endmodule

### design/swd_checker.sv
// swd_checker: port level checks for swipe_gesture_detector, bound to the top level
// depends on swd_pkg for the direction codes

module swd_checker
  import swd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // input back pressure only comes from a stalled result side
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("s_tready low without output stall");

  // nothing is presented right after reset
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // pad bits stay clear and codes beyond down never appear
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:3] == 5'd0 &&
      (m_tdata[2:0] == DIR_NONE || m_tdata[2:0] == DIR_LEFT ||
       m_tdata[2:0] == DIR_RIGHT || m_tdata[2:0] == DIR_UP ||
       m_tdata[2:0] == DIR_DOWN))
    else $error("bad result word");

endmodule

bind swipe_gesture_detector swd_checker u_swd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### test/testbench.sv
// testbench: self-checking bench for swipe_gesture_detector, predicts the direction of every
// motion report and compares it with the result stream; depends on swd_pkg and the design

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import swd_pkg::*;

  localparam int QuietLimit = 5000;

  // tracks accumulators, cooldown and registers; holds the directions still to come
  class swipe_tracker;
    logic [ThreshW-1:0]      threshold;
    logic [CoolW-1:0]        cool_ms;
    logic signed [SumW-1:0]  sum_x;
    logic signed [SumW-1:0]  sum_y;
    logic [DeadlineW-1:0]    deadline;
    bit                      cooling;
    dir_t                    dir_q[$];
    int                      errors;

    function new();
      threshold = THRESHOLD_RESET;
      cool_ms   = COOLDOWN_RESET;
      sum_x     = '0;
      sum_y     = '0;
      deadline  = '0;
      cooling   = 1'b0;
      errors    = 0;
    endfunction

    function logic signed [SumW-1:0] sat_add(logic signed [SumW-1:0] acc,
                                             logic signed [DeltaW-1:0] d);
      logic signed [SumW:0] s;
      s = acc + d;
      if (s[SumW] != s[SumW-1]) begin
        return s[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
      end
      return s[SumW-1:0];
    endfunction

    function logic [SumW-1:0] magnitude(logic signed [SumW-1:0] v);
      return v[SumW-1] ? -v : v;
    endfunction

    function void take_report(item_t m);
      logic [SumW:0] total;
      dir_t          dir;
      dir = DIR_NONE;
      if (cooling) begin
        // motion during cooldown is thrown away
        sum_x = '0;
        sum_y = '0;
        if (m.sync_flag && {1'b0, m.time_ms} >= deadline) cooling = 1'b0;
      end else begin
        if (m.axis_select) sum_y = sat_add(sum_y, $signed(m.delta));
        else sum_x = sat_add(sum_x, $signed(m.delta));
        total = {1'b0, magnitude(sum_x)} + {1'b0, magnitude(sum_y)};
        if (m.sync_flag && total >= {1'b0, threshold}) begin
          // ties go to the horizontal axis
          if (magnitude(sum_x) >= magnitude(sum_y)) dir = sum_x[SumW-1] ? DIR_LEFT : DIR_RIGHT;
          else dir = sum_y[SumW-1] ? DIR_UP : DIR_DOWN;
          sum_x    = '0;
          sum_y    = '0;
          cooling  = 1'b1;
          deadline = {1'b0, m.time_ms} + cool_ms;
        end
      end
      dir_q.push_back(dir);
    endfunction

    function int pending();
      return dir_q.size();
    endfunction

    task report_error(string msg);
      errors++;
      if (errors <= 40) $display("ERROR at %0t: %s", $time, msg);
    endtask

    task match_direction(logic [7:0] tdata);
      dir_t want;
      if (dir_q.size() == 0) begin
        report_error($sformatf("result with none pending, direction %0d", tdata[2:0]));
        return;
      end
      want = dir_q.pop_front();
      if (tdata[2:0] !== want)
        report_error($sformatf("direction %0d, predicted %0d", tdata[2:0], want));
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             s_tvalid;
  logic             s_tready;
  logic [79:0]      s_tdata;   // [15:0] delta, [78:16] time_ms, [79] zero
  logic             s_tuser;   // [0] axis_select
  logic             s_tlast;   // sync_flag
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [7:0]       m_tdata;   // [2:0] direction, [7:3] zero

  swipe_tracker     tracker;
  int               burst_left;
  int               gap_pct;
  logic [TimeW-1:0] now_ms;
  int               stall_left = 0;
  int               stall_mode = 0;
  int               quiet = 0;

  swipe_gesture_detector u_top (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls in stretches: always ready, coin flip, or mostly stalled
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      default: m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.match_direction(m_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      quiet <= 0;
    end else if (quiet == QuietLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send(logic axis, logic signed [DeltaW-1:0] delta, logic sync,
                      logic [TimeW-1:0] t);
    item_t m;
    int    gap;
    m.axis_select = axis;
    m.delta       = delta;
    m.sync_flag   = sync;
    m.time_ms     = t;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 99) < gap_pct) begin
        gap = $urandom_range(1, 12);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, t, delta};
    s_tuser  <= axis;
    s_tlast  <= sync;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.take_report(m);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(logic idx, logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_THRESHOLD) tracker.threshold = value;
    else tracker.cool_ms = value[CoolW-1:0];
    @(posedge clk);
  endtask

  task automatic configure(logic [ThreshW-1:0] thr, logic [CoolW-1:0] cool);
    drain_results();
    apb_write(REG_THRESHOLD, thr);
    apb_write(REG_COOLDOWN, {16'd0, cool});
  endtask

  function automatic logic signed [DeltaW-1:0] rand_delta(int span);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh8000;
    if (r == 1) return 16'sh7FFF;
    if (span == 0) return DeltaW'($urandom);
    return DeltaW'($urandom_range(0, 2 * span) - span);
  endfunction

  // mostly whole frames closed by a sync report, with some stray reports mixed in
  task automatic run_frames(int count, int span, int step);
    int               sent;
    int               n;
    logic [TimeW-1:0] t;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) begin
        send(1'($urandom_range(0, 1)), DeltaW'($urandom), 1'($urandom_range(0, 1)),
             now_ms + $urandom_range(0, 1000));
        sent++;
      end else begin
        n = $urandom_range(0, 4);
        for (int k = 0; k < n; k++)
          send(1'($urandom_range(0, 1)), rand_delta(span), 1'b0, now_ms);
        send(1'($urandom_range(0, 1)), rand_delta(span), 1'b1, now_ms);
        sent += n + 1;
      end
      now_ms += $urandom_range(0, step);
      if (tracker.cooling && $urandom_range(0, 19) == 0) now_ms += $urandom_range(0, 70000);
      if (!tracker.cooling && $urandom_range(0, 49) == 0) begin
        t = TimeW'({$urandom, $urandom});
        if (&t[TimeW-1:30]) t[TimeW-1] = 1'b0;
        now_ms = t;
      end
      if ($urandom_range(0, 99) == 0) drain_results();
    end
  endtask

  initial begin
    logic [TimeW-1:0] t_max;
    t_max      = '1;
    tracker    = new();
    burst_left = 0;
    gap_pct    = 30;
    now_ms     = '0;
    rst      <= 1'b1;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= 1'b0;
    s_tlast  <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: threshold 100, cooldown 300
    send(0, 60, 0, 0);
    send(1, 40, 1, 1);
    send(0, 16'sh7FFF, 1, 100);
    send(1, 16'sh8000, 1, 301);
    send(0, -30, 0, 302);
    send(1, -70, 1, 303);
    send(0, 5, 0, 700);
    send(0, 0, 1, 603);
    send(0, -50, 0, 610);
    send(1, 50, 1, 611);
    send(1, 0, 1, 911);
    send(1, 99, 1, 912);
    send(1, 1, 1, 913);
    send(0, 0, 1, 1213);
    send(0, 16'sh7FFF, 0, 1300);
    send(0, 16'sh7FFF, 1, 1301);
    send(1, 0, 1, 1601);
    send(1, 16'sh8000, 0, 1700);
    send(0, 100, 1, 1701);
    send(0, 0, 1, 2001);

    // zero threshold fires on empty accumulators; deadline at the top timestamp
    configure(32'd0, 16'd0);
    send(0, 0, 1, 5000);
    send(0, 0, 1, 5000);
    send(0, -5, 0, 5001);
    send(1, 5, 1, 5002);
    send(1, 0, 1, 5002);
    send(1, 0, 1, t_max);
    send(0, 7, 0, t_max);
    send(0, 0, 1, t_max);
    now_ms = 6000;

    configure(32'd100, 16'd300);
    run_frames(200, 80, 30);
    configure(32'd0, 16'd0);
    gap_pct = 0;
    run_frames(200, 4, 2);
    configure(32'd1, 16'd1);
    gap_pct = 60;
    run_frames(200, 0, 5);
    configure(32'd2500, 16'd45);
    gap_pct = 30;
    run_frames(200, 1200, 20);
    configure(32'd60000, 16'hFFFF);
    run_frames(200, 0, 50);

    // largest threshold: a short run of reports never reaches it
    configure(32'hFFFF_FFFF, 16'd7);
    run_frames(20, 0, 10);

    drain_results();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
